### hdl/ifhg_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header generator package
// Request and result types, controller commands and status, shared constants.
// ----------------------------------------------------------------------------
package ifhg_pkg;

  typedef enum logic {
    OpLoad = 1'b0,
    OpEmit = 1'b1
  } ifhg_op_e;

  typedef struct packed {
    logic        opcode;
    logic [4:0]  word_index;
    logic [15:0] header_word;
    logic [15:0] packet_length;
  } ifhg_in_t;

  typedef struct packed {
    logic [15:0] fragment_total_length;
    logic [15:0] offset_field;
    logic        more_fragments;
    logic [15:0] header_checksum;
    logic [15:0] payload_start;
    logic [15:0] payload_length;
    logic        unfragmented;
    logic        last_fragment;
    logic        header_error;
  } ifhg_out_t;

  typedef struct packed {
    logic wr_en;
    logic cap_in;
    logic hdr_cap;
    logic frag_cap;
    logic sweep;
    logic res_load;
  } ifhg_cmd_t;

  typedef struct packed {
    logic hdr_err;
    logic sum_last;
  } ifhg_sts_t;

  localparam logic [15:0] CfgReset    = 16'd1480;
  localparam logic [15:0] MinMtu      = 16'd8;
  localparam logic [3:0]  MinIhl      = 4'd5;
  localparam int unsigned FragNumW    = 14;
  localparam int unsigned SumW        = 21;
  localparam int unsigned WordTotLen  = 1;
  localparam int unsigned WordFragOff = 3;
  localparam int unsigned WordCksum   = 5;

endpackage

### hdl/ifhg_datapath.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header datapath
// Header word store, length checks, fragment position, checksum sweep and
// result register.
// ----------------------------------------------------------------------------
module ifhg_datapath
  import ifhg_pkg::*;
#(
  parameter int unsigned MAX_HEADER_WORDS = 30
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ifhg_in_t   in_data_i,
  input  logic       cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  ifhg_cmd_t  cmd_i,
  output ifhg_sts_t  sts_o,
  output ifhg_out_t  out_data_o
);

  localparam int unsigned PW = $clog2(MAX_HEADER_WORDS);
  localparam logic [5:0]  MaxWords = 6'(MAX_HEADER_WORDS);
  localparam logic [PW:0] Depth    = (PW+1)'(MAX_HEADER_WORDS);

  logic [15:0] mem [MAX_HEADER_WORDS];
  logic [15:0] rdata_q;
  logic [PW:0] rd_addr;

  logic [15:0] cfg_q;
  logic [15:0] plen_q;
  logic [FragNumW-1:0] frag_q, fnext_q;

  logic [5:0]  hlen_q;
  logic [4:0]  hwords_q;
  logic [15:0] dlen_q, mtu_q;
  logic        err_q, unfrag_q;
  logic [29:0] start_raw_q;
  logic [15:0] start_q, fdl_q, off_q;
  logic        mf_q;
  logic [PW-1:0] pos_q;
  logic [SumW-1:0] sum_q;
  logic [15:0] w1_q, w3_q, w5_q;
  ifhg_out_t   out_q, out_d;

  logic [15:0] mtu_raw, mtu_c;
  logic [3:0]  ihl;
  logic [5:0]  hlen_c;
  logic [4:0]  hwords_c;
  logic [15:0] hlen_ext, dlen_c;
  logic [29:0] prod_c;
  logic        restart;
  logic [15:0] start_c, rem_c, fdl_c;
  logic        mf_c;
  logic [FragNumW-1:0] f_eff;
  logic [15:0] word_c;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign rd_addr = cmd_i.sweep ? ({1'b0, pos_q} + (PW+1)'(1)) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (in_data_i.word_index < 5'(MAX_HEADER_WORDS))) begin
      mem[in_data_i.word_index[PW-1:0]] <= in_data_i.header_word;
    end
    if (rd_addr < Depth) begin
      rdata_q <= mem[rd_addr[PW-1:0]];
    end
  end

  assign mtu_raw  = {cfg_q[15:3], 3'b000};
  assign mtu_c    = (mtu_raw == 16'd0) ? MinMtu : mtu_raw;
  assign ihl      = rdata_q[11:8];
  assign hlen_c   = {ihl, 2'b00};
  assign hwords_c = {ihl, 1'b0};
  assign hlen_ext = {10'd0, hlen_c};
  assign dlen_c   = plen_q - hlen_ext;
  assign prod_c   = 30'(frag_q) * 30'(mtu_c);

  assign sts_o.hdr_err  = (ihl < MinIhl) || (hlen_ext > plen_q) ||
                          ({1'b0, hwords_c} > MaxWords);
  assign sts_o.sum_last = ((6'(pos_q) + 6'd1) == {1'b0, hwords_q});

  assign restart = (start_raw_q >= {14'd0, dlen_q});
  assign start_c = restart ? 16'd0 : start_raw_q[15:0];
  assign f_eff   = restart ? '0 : frag_q;
  assign rem_c   = dlen_q - start_c;
  assign mf_c    = (rem_c > mtu_q);
  assign fdl_c   = mf_c ? mtu_q : rem_c;

  always_comb begin
    word_c = rdata_q;
    if (pos_q == PW'(WordTotLen)) begin
      word_c = {10'd0, hlen_q} + fdl_q;
    end else if (pos_q == PW'(WordFragOff)) begin
      word_c = off_q;
    end else if (pos_q == PW'(WordCksum)) begin
      word_c = 16'd0;
    end
  end

  assign fold1 = {1'b0, sum_q[15:0]} + 17'(sum_q[SumW-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    out_d = '0;
    if (err_q) begin
      out_d.last_fragment = 1'b1;
      out_d.header_error  = 1'b1;
    end else if (unfrag_q) begin
      out_d.fragment_total_length = w1_q;
      out_d.offset_field          = w3_q;
      out_d.more_fragments        = w3_q[13];
      out_d.header_checksum       = w5_q;
      out_d.payload_length        = dlen_q;
      out_d.unfragmented          = 1'b1;
      out_d.last_fragment         = 1'b1;
    end else begin
      out_d.fragment_total_length = {10'd0, hlen_q} + fdl_q;
      out_d.offset_field          = off_q;
      out_d.more_fragments        = mf_q;
      out_d.header_checksum       = ~fold2;
      out_d.payload_start         = start_q;
      out_d.payload_length        = fdl_q;
      out_d.last_fragment         = ~mf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= CfgReset;
      frag_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.res_load) begin
        frag_q <= (err_q || unfrag_q) ? '0 : fnext_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      plen_q <= in_data_i.packet_length;
    end
    if (cmd_i.hdr_cap) begin
      hlen_q      <= hlen_c;
      hwords_q    <= hwords_c;
      dlen_q      <= dlen_c;
      mtu_q       <= mtu_c;
      err_q       <= sts_o.hdr_err;
      unfrag_q    <= (dlen_c <= mtu_c);
      start_raw_q <= prod_c;
    end
    if (cmd_i.frag_cap) begin
      start_q <= start_c;
      fdl_q   <= fdl_c;
      mf_q    <= mf_c;
      off_q   <= {2'b00, mf_c, start_c[15:3]};
      fnext_q <= mf_c ? (f_eff + FragNumW'(1)) : '0;
      pos_q   <= '0;
      sum_q   <= '0;
    end
    if (cmd_i.sweep) begin
      sum_q <= sum_q + SumW'(word_c);
      pos_q <= pos_q + PW'(1);
      if (pos_q == PW'(WordTotLen)) begin
        w1_q <= rdata_q;
      end
      if (pos_q == PW'(WordFragOff)) begin
        w3_q <= rdata_q;
      end
      if (pos_q == PW'(WordCksum)) begin
        w5_q <= rdata_q;
      end
    end
    if (cmd_i.res_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

### hdl/ifhg_ctrl.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header controller
// Sequences request intake, header checks, checksum sweep and result handoff.
// ----------------------------------------------------------------------------
module ifhg_ctrl
  import ifhg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_opcode_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ifhg_sts_t sts_i,
  output ifhg_cmd_t cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StHdr  = 3'd1;
  localparam logic [2:0] StFrag = 3'd2;
  localparam logic [2:0] StSum  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_opcode_i == OpEmit) begin
            cmd_o.cap_in = 1'b1;
            state_d      = StHdr;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      StHdr: begin
        cmd_o.hdr_cap = 1'b1;
        state_d       = sts_i.hdr_err ? StDone : StFrag;
      end
      StFrag: begin
        cmd_o.frag_cap = 1'b1;
        state_d        = StSum;
      end
      StSum: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sum_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hdl/ipv4_fragment_header_gen.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header generator
// Builds length, flags/offset and checksum fields for successive fragments.
// ----------------------------------------------------------------------------
// Requests arrive on a valid/ready channel. A load request writes one 16-bit
// header word into the word store; it keeps the block idle and gives no result.
// An emit request carries the packet length and returns one result on the
// valid/ready result channel: the next fragment's fields, the unchanged
// header values when the payload fits, or an error flag for a bad header length.
// An emit runs the header check, the fragment position step, a checksum sweep
// over the N header words, N being the header length in 16-bit words (10 to
// 30), which reads the word store one word per cycle, and the result load;
// an error skips the fragment step and the sweep. The next request can be
// taken as soon as the result is registered.
// The result register lets intake go on while a result waits; a stalled
// receiver holds the block only when a second result is ready.
// Reset clears the fragment counter and sets the payload limit to 1480;
// the word store is not cleared. Write the limit only while idle.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_gen
  import ifhg_pkg::*;
#(
  parameter int unsigned MAX_HEADER_WORDS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ifhg_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ifhg_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  ifhg_cmd_t cmd;
  ifhg_sts_t sts;

  ifhg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ifhg_datapath #(
    .MAX_HEADER_WORDS (MAX_HEADER_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

### hdl/ifhg_checker.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header checker
// Port-level properties of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module ifhg_checker
  import ifhg_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input ifhg_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input ifhg_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.header_error |->
      out_data_o.last_fragment && !out_data_o.unfragmented &&
      out_data_o.fragment_total_length == 16'd0 && out_data_o.payload_length == 16'd0)
    else $error("error result carries field data");

  a_unfrag_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.unfragmented |->
      out_data_o.last_fragment && !out_data_o.header_error &&
      out_data_o.payload_start == 16'd0)
    else $error("unfragmented result malformed");

  a_frag_mf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.unfragmented && !out_data_o.header_error |->
      out_data_o.more_fragments != out_data_o.last_fragment &&
      out_data_o.offset_field[13] == out_data_o.more_fragments)
    else $error("MF and last fragment disagree");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode == OpEmit) |=> !in_ready_o)
    else $error("request taken during emit");

endmodule

bind ipv4_fragment_header_gen ifhg_checker u_ifhg_checker (.*);

### bench/ipv4_fragment_header_gen_tb.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header generator testbench
// Drives header loads and fragment emits with random pacing on both channels,
// predicts every fragment descriptor and compares results field by field.
// The payload limit is swept across its range between drained phases.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_gen_tb
  import ifhg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HdrWords    = 30;
  localparam int unsigned QuietCycles = 40;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned PhaseItems  = 172;
  localparam int unsigned MaxFrags    = 12;

  class frag_scoreboard;
    bit [15:0]   words[HdrWords];
    bit [13:0]   frag_idx;
    bit [15:0]   limit_cfg;
    ifhg_out_t   pending_q[$];
    int unsigned errors;

    function new();
      frag_idx  = '0;
      limit_cfg = CfgReset;
      errors    = 0;
    endfunction

    function void set_limit(bit [15:0] value);
      limit_cfg = value;
    endfunction

    function void note_request(ifhg_in_t req);
      ifhg_out_t   res;
      int unsigned hlen, hwords, datalen, mtu, f, start, fdl, off, sum, w, i;
      bit          mf;
      if (req.opcode == OpLoad) begin
        if (req.word_index < HdrWords) words[req.word_index] = req.header_word;
        return;
      end
      res    = '0;
      hlen   = words[0][11:8] * 4;
      hwords = hlen / 2;
      if (hlen < 20 || hlen > req.packet_length || hwords > HdrWords) begin
        res.last_fragment = 1'b1;
        res.header_error  = 1'b1;
        frag_idx          = '0;
      end else begin
        datalen = req.packet_length - hlen;
        mtu     = 32'(limit_cfg & 16'hFFF8);
        if (mtu == 0) mtu = 32'(MinMtu);
        if (datalen <= mtu) begin
          res.fragment_total_length = words[WordTotLen];
          res.offset_field          = words[WordFragOff];
          res.more_fragments        = words[WordFragOff][13];
          res.header_checksum       = words[WordCksum];
          res.payload_start         = '0;
          res.payload_length        = datalen[15:0];
          res.unfragmented          = 1'b1;
          res.last_fragment         = 1'b1;
          frag_idx                  = '0;
        end else begin
          f     = 32'(frag_idx);
          start = f * mtu;
          if (start >= datalen) begin
            f     = 0;
            start = 0;
          end
          fdl = datalen - start;
          if (fdl > mtu) fdl = mtu;
          mf  = (start + fdl) < datalen;
          off = ((start / 8) & 32'h1FFF) | (mf ? 32'h2000 : 32'h0);
          sum = 0;
          for (i = 0; i < hwords; i++) begin
            if (i == WordTotLen) w = (hlen + fdl) & 32'hFFFF;
            else if (i == WordFragOff) w = off;
            else if (i == WordCksum) w = 0;
            else w = 32'(words[i]);
            sum += w;
          end
          while (sum > 32'hFFFF) sum = (sum & 32'hFFFF) + (sum >> 16);
          res.fragment_total_length = 16'(hlen + fdl);
          res.offset_field          = 16'(off);
          res.more_fragments        = mf;
          res.header_checksum       = ~sum[15:0];
          res.payload_start         = 16'(start);
          res.payload_length        = 16'(fdl);
          res.unfragmented          = 1'b0;
          res.last_fragment         = !mf;
          res.header_error          = 1'b0;
          frag_idx                  = mf ? 14'(f + 1) : 14'd0;
        end
      end
      pending_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
      end
    endfunction

    function void check_result(ifhg_out_t got);
      ifhg_out_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      want = pending_q.pop_front();
      compare_field("fragment_total_length", want.fragment_total_length,
                    got.fragment_total_length);
      compare_field("offset_field", want.offset_field, got.offset_field);
      compare_field("more_fragments", 16'(want.more_fragments),
                    16'(got.more_fragments));
      compare_field("header_checksum", want.header_checksum, got.header_checksum);
      compare_field("payload_start", want.payload_start, got.payload_start);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("unfragmented", 16'(want.unfragmented), 16'(got.unfragmented));
      compare_field("last_fragment", 16'(want.last_fragment),
                    16'(got.last_fragment));
      compare_field("header_error", 16'(want.header_error), 16'(got.header_error));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  ifhg_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  ifhg_out_t   out_data_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  frag_scoreboard sb;
  bit [15:0]      shadow_word0;
  bit             word_set[HdrWords];
  bit [15:0]      cur_limit;
  bit             steady;
  int unsigned    sent;
  int unsigned    quiet_cnt;

  ipv4_fragment_header_gen #(
    .MAX_HEADER_WORDS(HdrWords)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cnt = 0;
      end else begin
        quiet_cnt++;
        if (quiet_cnt >= StallLimit) begin
          $display("%0t: no request or result accepted for %0d cycles", $time, StallLimit);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  task automatic send_req(ifhg_in_t req);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (req.opcode == OpEmit || req.word_index < HdrWords) sent++;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic load_word(int unsigned idx, bit [15:0] value);
    ifhg_in_t req;
    req.opcode        = OpLoad;
    req.word_index    = idx[4:0];
    req.header_word   = value;
    req.packet_length = 16'($urandom);
    if (idx < HdrWords) begin
      word_set[idx] = 1'b1;
      if (idx == 0) shadow_word0 = value;
    end
    send_req(req);
  endtask

  task automatic emit(bit [15:0] plen);
    ifhg_in_t req;
    req.opcode        = OpEmit;
    req.word_index    = 5'($urandom);
    req.header_word   = 16'($urandom);
    req.packet_length = plen;
    send_req(req);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(bit [15:0] value);
    drain();
    repeat (QuietCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sb.set_limit(value);
    cur_limit = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int unsigned eff_mtu();
    int unsigned mtu;
    mtu = 32'(cur_limit & 16'hFFF8);
    return (mtu == 0) ? 32'(MinMtu) : mtu;
  endfunction

  function automatic bit header_ready();
    int unsigned hw, i;
    if (!word_set[0]) return 1'b0;
    hw = shadow_word0[11:8] * 2;
    for (i = 0; i < hw; i++) if (!word_set[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit [15:0] phase_limit(int unsigned p);
    case (p)
      1:       return 16'd8;
      2:       return 16'd65528;
      3:       return 16'd0;
      4:       return 16'hFFFF;
      5:       return 16'd576;
      6:       return 16'd7;
      7:       return {13'($urandom_range(1, 8191)), 3'b000};
      8:       return 16'($urandom);
      default: return CfgReset;
    endcase
  endfunction

  task automatic run_directed();
    load_word(0, 16'h4500);
    load_word(1, 16'h05DC);
    load_word(2, 16'hFFFF);
    load_word(3, 16'h4000);
    load_word(4, 16'h0000);
    load_word(5, 16'h1234);
    load_word(6, 16'hC0A8);
    load_word(7, 16'h0001);
    load_word(8, 16'hFFFF);
    load_word(9, 16'h0000);
    emit(16'd20);
    emit(16'd1500);
    emit(16'd1501);
    emit(16'd1501);
    emit(16'd0);
    emit(16'd3000);
    emit(16'd3000);
    emit(16'd1600);
    emit(16'd1600);
    emit(16'hFFFF);
    load_word(31, 16'hFFFF);
    load_word(30, 16'h0000);
    load_word(0, 16'h4400);
    emit(16'hFFFF);
    load_word(0, 16'h4500);
  endtask

  task automatic run_packet();
    int unsigned ihl, hlen, hw, mtu, datalen, nfrag, n, plen, i;
    bit          full;
    bit [15:0]   w0;
    ihl  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
    hlen = ihl * 4;
    hw   = hlen / 2;
    full = $urandom_range(0, 1);
    w0   = 16'($urandom);
    w0[11:8] = ihl[3:0];
    load_word(0, w0);
    for (i = 1; i < hw; i++)
      if (full || !word_set[i] || $urandom_range(0, 7) == 0) load_word(i, 16'($urandom));
    mtu = eff_mtu();
    case ($urandom_range(0, 9))
      0:       plen = $urandom_range(0, 65535);
      1:       plen = hlen + mtu;
      2:       plen = hlen + mtu + 1;
      3:       plen = (hlen == 0) ? 0 : $urandom_range(0, hlen - 1);
      4:       plen = hlen;
      5:       plen = 65535;
      default: plen = hlen + $urandom_range(1, mtu * $urandom_range(1, 5));
    endcase
    if (plen > 65535) plen = 65535;
    if (hlen < 20 || plen < hlen) begin
      nfrag = 1;
    end else begin
      datalen = plen - hlen;
      nfrag   = (datalen <= mtu) ? 1 : (datalen + mtu - 1) / mtu;
    end
    n = (nfrag > MaxFrags) ? MaxFrags : nfrag;
    if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
    repeat (n) emit(plen[15:0]);
  endtask

  task automatic run_noise();
    case ($urandom_range(0, 2))
      0: load_word($urandom_range(0, 31), 16'($urandom));
      1: begin
        if (header_ready()) emit(16'($urandom));
        else load_word(0, {8'h45, 8'($urandom)});
      end
      default: load_word($urandom_range(30, 31), 16'($urandom));
    endcase
  endtask

  initial begin
    int unsigned target, mid, p;
    bit          paused;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    steady       = 1'b0;
    sent         = 0;
    quiet_cnt    = 0;
    shadow_word0 = '0;
    cur_limit    = CfgReset;
    sb           = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (p = 0; p < NumPhases; p++) begin
      if (p > 0) write_limit(phase_limit(p));
      target = sent + PhaseItems;
      mid    = sent + PhaseItems / 2;
      paused = 1'b0;
      while (sent < target) begin
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 8) run_packet();
        else repeat ($urandom_range(1, 3)) run_noise();
        if (!paused && sent >= mid) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    drain();
    repeat (QuietCycles) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/ifhg_pkg.sv
hdl/ifhg_datapath.sv
hdl/ifhg_ctrl.sv
hdl/ipv4_fragment_header_gen.sv
hdl/ifhg_checker.sv
bench/ipv4_fragment_header_gen_tb.sv
